// ===== design/segment_to_segment_distance_assert.svh =====
// assertion macros shared by the segment distance design
`ifndef SEGMENT_TO_SEGMENT_DISTANCE_ASSERT_SVH
`define SEGMENT_TO_SEGMENT_DISTANCE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ssd_pkg.sv =====
// types and constants of the segment distance pipeline
`default_nettype none
package ssd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int LANES      = 4;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = 2 * COORD_BITS + 1;
    localparam int LO_W      = MAG_W / 2;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int NUM_W     = SQ_W + 2 * FRAC_BITS;
    localparam int DEN_W     = 2 * COORD_BITS + 1;
    localparam int QBITS     = 2 * COORD_BITS + 2 * FRAC_BITS + 1;
    localparam int DIST_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int ROOT_BITS = DIST_BITS;
    localparam int RAD_W     = 2 * ROOT_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } pair_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 touching;
    } result_t;

    typedef struct packed {
        logic valid;
        logic touch;
    } ctl_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_in_t;

    typedef div_in_t [LANES-1:0] div_lanes_t;
    typedef logic [LANES-1:0][QBITS-1:0] quot_lanes_t;

endpackage
`default_nettype wire

// ===== design/ssd_front.sv =====
// front end: differences, products, touch test and divider operands
`default_nettype none
module ssd_front
    import ssd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire pair_t src,
    input  wire logic  src_valid,
    output ctl_t       ctl,
    output div_lanes_t lanes
);

    localparam int NSTG = 6;
    localparam logic signed [SUM_W-1:0] ZERO_S = '0;

    // lane points: start, end of the segment and the probe point
    logic signed [COORD_BITS-1:0] sx [LANES];
    logic signed [COORD_BITS-1:0] sy [LANES];
    logic signed [COORD_BITS-1:0] ex [LANES];
    logic signed [COORD_BITS-1:0] ey [LANES];
    logic signed [COORD_BITS-1:0] px [LANES];
    logic signed [COORD_BITS-1:0] py [LANES];

    logic [NSTG-1:0] vld_reg;

    logic signed [DIFF_W-1:0] vx_reg [LANES];
    logic signed [DIFF_W-1:0] vy_reg [LANES];
    logic signed [DIFF_W-1:0] wx_reg [LANES];
    logic signed [DIFF_W-1:0] wy_reg [LANES];
    logic signed [DIFF_W-1:0] zx_reg [LANES];
    logic signed [DIFF_W-1:0] zy_reg [LANES];

    logic signed [PROD_W-1:0] p_vxwy_reg [LANES];
    logic signed [PROD_W-1:0] p_vywx_reg [LANES];
    logic signed [PROD_W-1:0] p_vxvx_reg [LANES];
    logic signed [PROD_W-1:0] p_vyvy_reg [LANES];
    logic signed [PROD_W-1:0] p_wxvx_reg [LANES];
    logic signed [PROD_W-1:0] p_wyvy_reg [LANES];
    logic signed [PROD_W-1:0] p_wxwx_reg [LANES];
    logic signed [PROD_W-1:0] p_wywy_reg [LANES];
    logic signed [PROD_W-1:0] p_zxzx_reg [LANES];
    logic signed [PROD_W-1:0] p_zyzy_reg [LANES];
    logic signed [PROD_W-1:0] p_wxzx_reg [LANES];
    logic signed [PROD_W-1:0] p_wyzy_reg [LANES];

    logic signed [SUM_W-1:0] c_reg  [LANES];
    logic signed [SUM_W-1:0] d_reg  [LANES];
    logic signed [SUM_W-1:0] dt_reg [LANES];
    logic signed [SUM_W-1:0] qw_reg [LANES];
    logic signed [SUM_W-1:0] qz_reg [LANES];
    logic signed [SUM_W-1:0] oz_reg [LANES];

    logic [LANES-1:0]        on_seg;
    logic [LANES-1:0]        is_int;
    logic [DEN_W-1:0]        ept   [LANES];
    logic [MAG_W-1:0]        mag   [LANES];
    logic signed [SUM_W-1:0] neg_c [LANES];
    logic                    touch_next;

    logic [LANES-1:0] int4_reg;
    logic [DEN_W-1:0] ept4_reg [LANES];
    logic [DEN_W-1:0] den4_reg [LANES];
    logic [MAG_W-1:0] mag4_reg [LANES];
    logic             touch4_reg;

    logic [2*HI_W-1:0]      hh_reg [LANES];
    logic [HI_W+LO_W-1:0]   hl_reg [LANES];
    logic [2*LO_W-1:0]      ll_reg [LANES];
    logic [LANES-1:0]       int5_reg;
    logic [DEN_W-1:0]       ept5_reg [LANES];
    logic [DEN_W-1:0]       den5_reg [LANES];
    logic                   touch5_reg;

    logic [SQ_W-1:0] sq [LANES];
    div_lanes_t      lanes_reg;
    logic            touch6_reg;

    function automatic logic is_pos(input logic signed [SUM_W-1:0] x);
        return !x[SUM_W-1] && (x != ZERO_S);
    endfunction

    function automatic logic opposite(input logic signed [SUM_W-1:0] a,
                                      input logic signed [SUM_W-1:0] b);
        return (is_pos(a) && b[SUM_W-1]) || (a[SUM_W-1] && is_pos(b));
    endfunction

    // lane k measures point p against segment s..e
    always_comb
    begin
        sx[0] = src.first_start_x;  sy[0] = src.first_start_y;
        ex[0] = src.first_end_x;    ey[0] = src.first_end_y;
        px[0] = src.second_start_x; py[0] = src.second_start_y;
        sx[1] = src.first_start_x;  sy[1] = src.first_start_y;
        ex[1] = src.first_end_x;    ey[1] = src.first_end_y;
        px[1] = src.second_end_x;   py[1] = src.second_end_y;
        sx[2] = src.second_start_x; sy[2] = src.second_start_y;
        ex[2] = src.second_end_x;   ey[2] = src.second_end_y;
        px[2] = src.first_start_x;  py[2] = src.first_start_y;
        sx[3] = src.second_start_x; sy[3] = src.second_start_y;
        ex[3] = src.second_end_x;   ey[3] = src.second_end_y;
        px[3] = src.first_end_x;    py[3] = src.first_end_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], src_valid};
        end
    end

    // stage 1 to 3: differences, products, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                vx_reg[k] <= DIFF_W'(ex[k]) - DIFF_W'(sx[k]);
                vy_reg[k] <= DIFF_W'(ey[k]) - DIFF_W'(sy[k]);
                wx_reg[k] <= DIFF_W'(px[k]) - DIFF_W'(sx[k]);
                wy_reg[k] <= DIFF_W'(py[k]) - DIFF_W'(sy[k]);
                zx_reg[k] <= DIFF_W'(px[k]) - DIFF_W'(ex[k]);
                zy_reg[k] <= DIFF_W'(py[k]) - DIFF_W'(ey[k]);

                p_vxwy_reg[k] <= vx_reg[k] * wy_reg[k];
                p_vywx_reg[k] <= vy_reg[k] * wx_reg[k];
                p_vxvx_reg[k] <= vx_reg[k] * vx_reg[k];
                p_vyvy_reg[k] <= vy_reg[k] * vy_reg[k];
                p_wxvx_reg[k] <= wx_reg[k] * vx_reg[k];
                p_wyvy_reg[k] <= wy_reg[k] * vy_reg[k];
                p_wxwx_reg[k] <= wx_reg[k] * wx_reg[k];
                p_wywy_reg[k] <= wy_reg[k] * wy_reg[k];
                p_zxzx_reg[k] <= zx_reg[k] * zx_reg[k];
                p_zyzy_reg[k] <= zy_reg[k] * zy_reg[k];
                p_wxzx_reg[k] <= wx_reg[k] * zx_reg[k];
                p_wyzy_reg[k] <= wy_reg[k] * zy_reg[k];

                c_reg[k]  <= SUM_W'(p_vxwy_reg[k]) - SUM_W'(p_vywx_reg[k]);
                d_reg[k]  <= SUM_W'(p_vxvx_reg[k]) + SUM_W'(p_vyvy_reg[k]);
                dt_reg[k] <= SUM_W'(p_wxvx_reg[k]) + SUM_W'(p_wyvy_reg[k]);
                qw_reg[k] <= SUM_W'(p_wxwx_reg[k]) + SUM_W'(p_wywy_reg[k]);
                qz_reg[k] <= SUM_W'(p_zxzx_reg[k]) + SUM_W'(p_zyzy_reg[k]);
                oz_reg[k] <= SUM_W'(p_wxzx_reg[k]) + SUM_W'(p_wyzy_reg[k]);
            end
        end
    end

    // stage 4: classify projection, touch test
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            on_seg[k] = (c_reg[k] == ZERO_S) && (oz_reg[k] <= ZERO_S);
            is_int[k] = (d_reg[k] != ZERO_S) && (dt_reg[k] > ZERO_S)
                     && (dt_reg[k] < d_reg[k]);
            ept[k]    = ((d_reg[k] == ZERO_S) || (dt_reg[k] <= ZERO_S))
                      ? qw_reg[k][DEN_W-1:0] : qz_reg[k][DEN_W-1:0];
            neg_c[k]  = ZERO_S - c_reg[k];
            mag[k]    = c_reg[k][SUM_W-1] ? neg_c[k][MAG_W-1:0] : c_reg[k][MAG_W-1:0];
        end
        touch_next = (opposite(c_reg[2], c_reg[3]) && opposite(c_reg[0], c_reg[1]))
                  || (|on_seg);
    end

    // stage 5: cross squared as three partial products
    // stage 6: sum and pick dividend and divisor
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sq[k] = (SQ_W'(hh_reg[k]) << (2 * LO_W))
                  + (SQ_W'(hl_reg[k]) << (LO_W + 1))
                  + SQ_W'(ll_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            int4_reg   <= is_int;
            touch4_reg <= touch_next;
            touch5_reg <= touch4_reg;
            int5_reg   <= int4_reg;
            touch6_reg <= touch5_reg;
            for (int k = 0; k < LANES; k++)
            begin
                ept4_reg[k] <= ept[k];
                den4_reg[k] <= d_reg[k][DEN_W-1:0];
                mag4_reg[k] <= mag[k];

                hh_reg[k]   <= mag4_reg[k][MAG_W-1:LO_W] * mag4_reg[k][MAG_W-1:LO_W];
                hl_reg[k]   <= mag4_reg[k][MAG_W-1:LO_W] * mag4_reg[k][LO_W-1:0];
                ll_reg[k]   <= mag4_reg[k][LO_W-1:0] * mag4_reg[k][LO_W-1:0];
                ept5_reg[k] <= ept4_reg[k];
                den5_reg[k] <= den4_reg[k];

                lanes_reg[k].num <= int5_reg[k] ? (NUM_W'(sq[k]) << (2 * FRAC_BITS))
                                                : (NUM_W'(ept5_reg[k]) << (2 * FRAC_BITS));
                lanes_reg[k].den <= int5_reg[k] ? den5_reg[k] : DEN_W'(1);
            end
        end
    end

    assign ctl.valid = vld_reg[NSTG-1];
    assign ctl.touch = touch6_reg;
    assign lanes     = lanes_reg;

endmodule
`default_nettype wire

// ===== design/ssd_div.sv =====
// four-lane restoring divider, one quotient bit per stage
`default_nettype none
module ssd_div
    import ssd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire ctl_t       ctl_in,
    input  wire div_lanes_t lanes,
    output ctl_t            ctl_out,
    output quot_lanes_t     quot
);

    logic [DEN_W-1:0] rem_reg  [QBITS][LANES];
    logic [QBITS-1:0] lq_reg   [QBITS][LANES];
    logic [DEN_W-1:0] den_reg  [QBITS][LANES];
    logic [DEN_W-1:0] rem_src  [QBITS][LANES];
    logic [QBITS-1:0] lq_src   [QBITS][LANES];
    logic [DEN_W-1:0] den_src  [QBITS][LANES];
    logic [DEN_W-1:0] rem_next [QBITS][LANES];
    logic [QBITS-1:0] lq_next  [QBITS][LANES];
    logic [QBITS-1:0] vld_reg;
    logic [QBITS-1:0] touch_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // lq holds unconsumed dividend bits on top, quotient bits below
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rem_src[0][k] = lanes[k].num[NUM_W-1:QBITS];
            lq_src[0][k]  = lanes[k].num[QBITS-1:0];
            den_src[0][k] = lanes[k].den;
        end
        for (int j = 1; j < QBITS; j++)
        begin
            rem_src[j] = rem_reg[j-1];
            lq_src[j]  = lq_reg[j-1];
            den_src[j] = den_reg[j-1];
        end
    end

    always_comb
    begin
        trial = '0;
        diff  = '0;
        ge    = 1'b0;
        for (int j = 0; j < QBITS; j++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                trial = {rem_src[j][k], lq_src[j][k][QBITS-1]};
                diff  = trial - {1'b0, den_src[j][k]};
                ge    = (trial >= {1'b0, den_src[j][k]});
                rem_next[j][k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                lq_next[j][k]  = {lq_src[j][k][QBITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            lq_reg    <= lq_next;
            den_reg   <= den_src;
            touch_reg <= {touch_reg[QBITS-2:0], ctl_in.touch};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QBITS-2:0], ctl_in.valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            quot[k] = lq_reg[QBITS-1][k];
        end
    end

    assign ctl_out.valid = vld_reg[QBITS-1];
    assign ctl_out.touch = touch_reg[QBITS-1];

endmodule
`default_nettype wire

// ===== design/ssd_root.sv =====
// minimum over lanes and pipelined integer square root
`default_nettype none
module ssd_root
    import ssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire ctl_t        ctl_in,
    input  wire quot_lanes_t quot,
    output logic             valid,
    output result_t          result
);

    localparam int RB   = ROOT_BITS;
    localparam int NSTG = RB + 2;

    logic [QBITS-1:0] mlo_reg;
    logic [QBITS-1:0] mhi_reg;
    logic [QBITS-1:0] m_reg;
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  touch_reg;

    logic [RB+1:0]    rem_reg   [RB];
    logic [RB-1:0]    root_reg  [RB];
    logic [RAD_W-1:0] rad_reg   [RB];
    logic [RB+1:0]    rem_src   [RB];
    logic [RB-1:0]    root_src  [RB];
    logic [RAD_W-1:0] rad_src   [RB];
    logic [RB+1:0]    rem_next  [RB];
    logic [RB-1:0]    root_next [RB];
    logic [RAD_W-1:0] rad_next  [RB];
    logic [RB+1:0]    pre;
    logic [RB+1:0]    trial;
    logic             ge;

    always_comb
    begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rad_src[0]  = RAD_W'(m_reg);
        for (int j = 1; j < RB; j++)
        begin
            rem_src[j]  = rem_reg[j-1];
            root_src[j] = root_reg[j-1];
            rad_src[j]  = rad_reg[j-1];
        end
    end

    // one root bit per stage from two radicand bits
    always_comb
    begin
        pre   = '0;
        trial = '0;
        ge    = 1'b0;
        for (int j = 0; j < RB; j++)
        begin
            pre   = {rem_src[j][RB-1:0], rad_src[j][RAD_W-1 -: 2]};
            trial = {root_src[j], 2'b01};
            ge    = (pre >= trial);
            rem_next[j]  = ge ? (pre - trial) : pre;
            root_next[j] = {root_src[j][RB-2:0], ge};
            rad_next[j]  = rad_src[j] << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mlo_reg   <= (quot[0] < quot[1]) ? quot[0] : quot[1];
            mhi_reg   <= (quot[2] < quot[3]) ? quot[2] : quot[3];
            m_reg     <= (mlo_reg < mhi_reg) ? mlo_reg : mhi_reg;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            rad_reg   <= rad_next;
            touch_reg <= {touch_reg[NSTG-2:0], ctl_in.touch};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], ctl_in.valid};
        end
    end

    assign valid           = vld_reg[NSTG-1];
    assign result.touching = touch_reg[NSTG-1];
    assign result.distance = touch_reg[NSTG-1] ? '0 : root_reg[RB-1];

endmodule
`default_nettype wire

// ===== design/segment_to_segment_distance.sv =====
// top level of the segment to segment distance pipeline
`default_nettype none
//
//  channel   valid          stall          word
//  pair      pair_valid     pair_stall     pair   (two segments, eight coordinates)
//  result    result_valid   result_stall   result (distance, touching)
//
//  one word per cycle while the result is not stalled; 6 front stages, one divider
//  stage per quotient bit (49), 2 minimum stages, one root stage per root bit (25)
//  reset clears the valid bits and the input skid, payload registers are not reset
//  a stalled result freezes the whole pipe; the input skid still takes one more word
//  so pair_stall comes straight from a register
//
`include "segment_to_segment_distance_assert.svh"
module segment_to_segment_distance
    import ssd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pair_valid,
    output logic         pair_stall,
    input  wire pair_t   pair,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    // pipe advance: held only while the result word waits
    logic        en;
    // input skid
    pair_t       skid_reg;
    logic        skid_v_reg;
    logic        skid_v_next;
    pair_t       src;
    logic        src_valid;
    // stage links
    ctl_t        front_ctl;
    div_lanes_t  front_lanes;
    ctl_t        div_ctl;
    quot_lanes_t div_quot;

    assign en         = !(result_valid && result_stall);
    assign pair_stall = skid_v_reg;
    assign src        = skid_v_reg ? skid_reg : pair;
    assign src_valid  = skid_v_reg || pair_valid;

    // skid fills when the pipe is held and empties as soon as it moves
    always_comb
    begin
        if (en)
        begin
            skid_v_next = 1'b0;
        end
        else if (pair_valid && !skid_v_reg)
        begin
            skid_v_next = 1'b1;
        end
        else
        begin
            skid_v_next = skid_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else
        begin
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en && pair_valid && !skid_v_reg)
        begin
            skid_reg <= pair;
        end
    end

    // cross products, projections and divider operands per lane
    ssd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src       (src),
        .src_valid (src_valid),
        .ctl       (front_ctl),
        .lanes     (front_lanes)
    );

    // squared scaled distance per lane
    ssd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .lanes   (front_lanes),
        .ctl_out (div_ctl),
        .quot    (div_quot)
    );

    // smallest lane, then its root
    ssd_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (div_ctl),
        .quot   (div_quot),
        .valid  (result_valid),
        .result (result)
    );

    `SSD_ASSERT_IMP(a_touch_zero, clk, rst_n, result_valid && result.touching, result.distance == '0, "touching word carries a nonzero distance")
    `SSD_ASSERT_NXT(a_skid_hold, clk, rst_n, !en && skid_v_reg, skid_v_reg, "skid word dropped while the pipe was held")
    `SSD_ASSERT_IMP(a_skid_fill, clk, rst_n, $rose(skid_v_reg), $past(!en && pair_valid), "skid filled without a held pipe and a valid word")

endmodule
`default_nettype wire
